// File: rtl/core/hdlctx_pkg.sv
package hdlctx_pkg;

  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
  localparam logic [2:0]  STUFF_RUN      = 3'd5;
  localparam logic [15:0] MAX_BITS_RESET = 16'd2048;
  localparam int          CFG_W          = 16;
  localparam int          SCR_LEN        = 17;
  localparam int          SCR_TAP_HI     = 16;
  localparam int          SCR_TAP_LO     = 11;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_FLAG  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_FSK_MODE = 1'b0,
    REG_MAX_BITS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEG_CRC_LO = 2'd0,
    SEG_CRC_HI = 2'd1,
    SEG_FLAG   = 2'd2
  } seg_t;

  // line coder control, one bit step at a time
  typedef struct packed {
    logic clear;
    logic advance;
    logic fsk;
  } coder_ctrl_t;

endpackage

// File: rtl/core/hdlctx_line_coder.sv
module hdlctx_line_coder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hdlctx_pkg::coder_ctrl_t  ctrl,
  input  logic                     bit_in,
  output logic                     bit_out
);

  logic [hdlctx_pkg::SCR_LEN-1:0] scr_r;
  logic                           tone_r;
  logic                           scr_bit;

  assign scr_bit = bit_in ^ scr_r[hdlctx_pkg::SCR_TAP_HI] ^ scr_r[hdlctx_pkg::SCR_TAP_LO];
  // NRZI: a zero toggles the tone
  assign bit_out = ctrl.fsk ? (tone_r ^ ~scr_bit) : bit_in;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      scr_r  <= '0;
      tone_r <= 1'b0;
    end else if (ctrl.advance) begin
      scr_r  <= {scr_r[hdlctx_pkg::SCR_LEN-2:0], scr_bit};
      tone_r <= tone_r ^ ~scr_bit;
    end
  end

endmodule

// File: rtl/core/hdlc_tx_framer_scrambler.sv
// Bit-serial HDLC transmit framer with CRC-16, zero stuffing and optional
// scrambler plus NRZI line coding.
// Input channel: in_valid/in_stall carry a command (start, data byte, flag,
// end) and a data byte. in_stall is high while a command is being serialized;
// a start command is taken while idle and produces no output.
// Output channel: out_valid/out_stall carry one line bit per transaction,
// with out_last on the final bit of the command and out_overflow showing
// whether the frame bit limit was already hit.
// Throughput: the bit sequencer emits one bit per cycle into a single output
// register while the receiver does not stall; a data byte, flag or end
// command is serialized in full before the block returns to idle and takes
// the next command. An accepted command first moves the sequencer into its
// run state, and its first bit is then loaded into the output register.
// A byte or flag cut short by the bit limit ends at the dropped bit.
// When the receiver stalls, the output register holds and the sequencer
// waits; no bit is lost.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written by the user
// only while idle; the block does not enforce this. Reset clears frame state:
// CRC to all ones, counters, scrambler and tone; fsk_mode resets to 0 and max_bits to 2048.
module hdlc_tx_framer_scrambler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_line_bit,
  output logic                          out_last,
  output logic                          out_overflow,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [hdlctx_pkg::CFG_W-1:0]  cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                state_r;
  hdlctx_pkg::cmd_t      cmd_r;
  hdlctx_pkg::seg_t      seg_r;
  logic [7:0]            sh_r;
  logic [7:0]            crc_hi_r;
  logic [2:0]            idx_r;
  logic                  stuff_r;
  logic [2:0]            ones_r;
  logic [15:0]           crc_r;
  logic [15:0]           bit_count_r;
  logic                  ovf_r;
  logic                  fsk_r;
  logic [15:0]           max_bits_r;
  logic                  out_valid_r;
  logic                  out_line_bit_r;
  logic                  out_last_r;
  logic                  out_overflow_r;

  hdlctx_pkg::cmd_t        in_cmd_e;
  hdlctx_pkg::coder_ctrl_t coder_ctrl;
  logic                    step;
  logic                    emit;
  logic                    is_flag;
  logic                    more_segs;
  logic                    raw_bit;
  logic                    coded_bit;
  logic                    dropped;
  logic                    data_bit;
  logic [2:0]              ones_inc;
  logic                    need_stuff;
  logic                    more;
  logic                    last_bit;
  logic                    seg_done;
  logic [15:0]             crc_mix;
  logic [15:0]             crc_nxt;
  logic                    start_acc;

  assign in_cmd_e   = hdlctx_pkg::cmd_t'(in_cmd);
  assign in_stall   = (state_r != ST_IDLE);
  assign start_acc  = in_valid && !in_stall && (in_cmd_e == hdlctx_pkg::CMD_START);
  assign step       = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign emit       = step && !dropped;
  assign is_flag    = (cmd_r == hdlctx_pkg::CMD_FLAG) ||
                      ((cmd_r == hdlctx_pkg::CMD_END) && (seg_r == hdlctx_pkg::SEG_FLAG));
  assign more_segs  = (cmd_r == hdlctx_pkg::CMD_END) && (seg_r != hdlctx_pkg::SEG_FLAG);
  assign raw_bit    = stuff_r ? 1'b0 : sh_r[0];
  assign dropped    = (bit_count_r >= max_bits_r);
  assign data_bit   = !is_flag && !stuff_r;
  assign ones_inc   = ones_r + 3'd1;
  assign need_stuff = data_bit && sh_r[0] && (ones_inc >= hdlctx_pkg::STUFF_RUN);
  assign more       = need_stuff || (idx_r != 3'd7) || more_segs;
  assign last_bit   = !more || (({1'b0, bit_count_r} + 17'd1) >= {1'b0, max_bits_r});
  assign seg_done   = dropped || (!need_stuff && (idx_r == 3'd7));
  assign crc_mix    = crc_r ^ {15'd0, sh_r[0]};
  assign crc_nxt    = crc_mix[0] ? ((crc_mix >> 1) ^ hdlctx_pkg::CRC_POLY) : (crc_mix >> 1);

  assign coder_ctrl.clear   = start_acc;
  assign coder_ctrl.advance = step && !dropped && fsk_r;
  assign coder_ctrl.fsk     = fsk_r;

  hdlctx_line_coder u_coder (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (coder_ctrl),
    .bit_in  (raw_bit),
    .bit_out (coded_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fsk_r       <= 1'b0;
      max_bits_r  <= hdlctx_pkg::MAX_BITS_RESET;
      crc_r       <= hdlctx_pkg::CRC_INIT;
      ones_r      <= '0;
      bit_count_r <= '0;
      ovf_r       <= 1'b0;
      stuff_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (hdlctx_pkg::reg_idx_t'(cfg_index))
          hdlctx_pkg::REG_FSK_MODE: fsk_r      <= cfg_wdata[0];
          hdlctx_pkg::REG_MAX_BITS: max_bits_r <= cfg_wdata[15:0];
        endcase
      end
      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_cmd_e;
            seg_r   <= hdlctx_pkg::SEG_CRC_LO;
            idx_r   <= '0;
            stuff_r <= 1'b0;
            unique case (in_cmd_e)
              hdlctx_pkg::CMD_START: begin
                crc_r       <= hdlctx_pkg::CRC_INIT;
                ones_r      <= '0;
                bit_count_r <= '0;
                ovf_r       <= 1'b0;
              end
              hdlctx_pkg::CMD_DATA: begin
                sh_r    <= in_data_byte;
                state_r <= ST_RUN;
              end
              hdlctx_pkg::CMD_FLAG: begin
                sh_r    <= hdlctx_pkg::FLAG_BYTE;
                state_r <= ST_RUN;
              end
              hdlctx_pkg::CMD_END: begin
                sh_r     <= ~crc_r[7:0];
                crc_hi_r <= ~crc_r[15:8];
                state_r  <= ST_RUN;
              end
            endcase
          end
        end
        ST_RUN: begin
          if (step) begin
            if (data_bit) begin
              crc_r <= crc_nxt;
            end
            if (dropped) begin
              ovf_r <= 1'b1;
            end else begin
              out_valid_r    <= 1'b1;
              out_line_bit_r <= coded_bit;
              out_last_r     <= last_bit;
              out_overflow_r <= ovf_r;
              bit_count_r    <= bit_count_r + 16'd1;
              if (!is_flag) begin
                if (stuff_r || !sh_r[0]) begin
                  ones_r <= '0;
                end else begin
                  ones_r <= ones_inc;
                end
              end
            end
            if (seg_done) begin
              stuff_r <= 1'b0;
              idx_r   <= '0;
              if (is_flag) begin
                ones_r <= '0;
              end
              if (more_segs) begin
                if (seg_r == hdlctx_pkg::SEG_CRC_LO) begin
                  seg_r <= hdlctx_pkg::SEG_CRC_HI;
                  sh_r  <= crc_hi_r;
                end else begin
                  seg_r <= hdlctx_pkg::SEG_FLAG;
                  sh_r  <= hdlctx_pkg::FLAG_BYTE;
                end
              end else begin
                state_r <= ST_IDLE;
              end
            end else if (need_stuff) begin
              stuff_r <= 1'b1;
            end else begin
              stuff_r <= 1'b0;
              idx_r   <= idx_r + 3'd1;
              sh_r    <= sh_r >> 1;
            end
          end
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_line_bit = out_line_bit_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_overflow_r;

`ifndef SYNTH
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN))
    else $error("output transaction without active command");

  a_stuff_run: assert property (@(posedge clk) disable iff (!rst_n)
    stuff_r |-> (ones_r >= hdlctx_pkg::STUFF_RUN))
    else $error("stuff bit pending below run length");

  a_count_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (bit_count_r != $past(bit_count_r)) && (bit_count_r != 16'd0))
      |-> out_valid_r)
    else $error("bit count moved without emitted bit");

  a_ovf_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(state_r == ST_RUN))
    else $error("overflow set outside a command");
`endif

endmodule

// File: tb/hdlc_tx_framer_scrambler_tb.sv
`timescale 1ns / 1ps

module hdlc_tx_framer_scrambler_tb;

  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [7:0]  FLAG_PAT  = 8'h7E;
  localparam int          ITEM_CAP  = 28;
  localparam int          SETTLE    = 64;
  localparam int          N_RANDOM  = 80;

  typedef struct packed {
    logic line_bit;
    logic last;
    logic overflow;
  } tx_bit_t;

  typedef struct {
    hdlctx_pkg::cmd_t cmd;
    logic [7:0]       data;
    int               gap;
    bit               drain;
  } tx_cmd_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  hdlctx_pkg::cmd_t     in_cmd = hdlctx_pkg::CMD_START;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_line_bit;
  logic                 out_last;
  logic                 out_overflow;
  logic                 cfg_we = 1'b0;
  hdlctx_pkg::reg_idx_t cfg_index = hdlctx_pkg::REG_FSK_MODE;
  logic [15:0]          cfg_wdata = 16'h0000;

  hdlc_tx_framer_scrambler u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_line_bit (out_line_bit),
    .out_last     (out_last),
    .out_overflow (out_overflow),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // framer state mirror
  logic [15:0] fcs_q;
  logic [2:0]  ones_q;
  logic [15:0] nbits_q;
  logic [16:0] scr_q;
  logic        tone_q;
  logic        ovf_q;
  logic        fsk_q;
  logic [15:0] max_bits_q;
  int          item_bits;

  tx_cmd_t pending_cmds[$];
  tx_bit_t line_bits_due[$];

  int  gap_cnt;
  int  stall_left;
  bit  calm;
  int  n_queued;
  int  n_sent;
  int  n_checked;
  int  n_cfg;
  int  err_cnt;
  tx_bit_t got_bit;
  tx_bit_t want_bit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_frame();
    fcs_q   = 16'hFFFF;
    ones_q  = 3'd0;
    nbits_q = 16'd0;
    scr_q   = 17'd0;
    tone_q  = 1'b0;
    ovf_q   = 1'b0;
  endfunction

  function automatic void fold_fcs(logic b);
    logic [15:0] c;
    c = fcs_q ^ {15'd0, b};
    fcs_q = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
  endfunction

  function automatic bit emit_bit(logic b);
    logic x;
    logic v;
    v = b;
    if (nbits_q >= max_bits_q || item_bits >= ITEM_CAP) begin
      ovf_q = 1'b1;
      return 1'b0;
    end
    if (fsk_q) begin
      x = v ^ scr_q[16] ^ scr_q[11];
      scr_q = {scr_q[15:0], x};
      if (!x) tone_q = ~tone_q;
      v = tone_q;
    end
    line_bits_due.push_back('{line_bit: v, last: 1'b0, overflow: ovf_q});
    item_bits++;
    nbits_q = nbits_q + 16'd1;
    return 1'b1;
  endfunction

  function automatic void send_octet(logic [7:0] v);
    logic b;
    for (int i = 0; i < 8; i++) begin
      b = v[i];
      fold_fcs(b);
      if (b) begin
        if (!emit_bit(1'b1)) return;
        ones_q = ones_q + 3'd1;
        if (ones_q < 3'd5) continue;
      end
      if (!emit_bit(1'b0)) return;
      ones_q = 3'd0;
    end
  endfunction

  function automatic void send_flag();
    for (int i = 0; i < 8; i++) begin
      if (!emit_bit(FLAG_PAT[i])) break;
    end
    ones_q = 3'd0;
  endfunction

  function automatic void predict_cmd(hdlctx_pkg::cmd_t cmd, logic [7:0] data);
    logic [15:0] fin;
    tx_bit_t tail;
    item_bits = 0;
    case (cmd)
      hdlctx_pkg::CMD_START: clear_frame();
      hdlctx_pkg::CMD_DATA:  send_octet(data);
      hdlctx_pkg::CMD_FLAG:  send_flag();
      default: begin
        fin = fcs_q;
        send_octet(~fin[7:0]);
        send_octet(~fin[15:8]);
        send_flag();
      end
    endcase
    if (item_bits > 0) begin
      tail = line_bits_due.pop_back();
      tail.last = 1'b1;
      line_bits_due.push_back(tail);
    end
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic queue_cmd(hdlctx_pkg::cmd_t cmd, logic [7:0] data, bit drain = 1'b0);
    tx_cmd_t c;
    c.cmd   = cmd;
    c.data  = data;
    c.gap   = calm ? 0 : $urandom_range(0, 14);
    c.drain = drain || ($urandom_range(0, 24) == 0);
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  task automatic queue_frame(int n_data);
    logic [7:0] b;
    queue_cmd(hdlctx_pkg::CMD_START, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0)
      queue_cmd(hdlctx_pkg::CMD_FLAG, 8'($urandom_range(0, 255)));
    repeat (n_data) begin
      case ($urandom_range(0, 5))
        0: b = 8'hFF;
        1: b = 8'h7E;
        default: b = 8'($urandom_range(0, 255));
      endcase
      queue_cmd(hdlctx_pkg::CMD_DATA, b);
    end
    if ($urandom_range(0, 4) != 0)
      queue_cmd(hdlctx_pkg::CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || line_bits_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(hdlctx_pkg::reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hdlctx_pkg::REG_FSK_MODE) fsk_q = val[0];
    else max_bits_q = val;
    n_cfg++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cmd(in_cmd, in_data_byte);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && gap_cnt >= pending_cmds[0].gap &&
            !(pending_cmds[0].drain && line_bits_due.size() != 0)) begin
          in_valid     <= 1'b1;
          in_cmd       <= pending_cmds[0].cmd;
          in_data_byte <= pending_cmds[0].data;
          void'(pending_cmds.pop_front());
          gap_cnt      <= 0;
        end else begin
          in_valid <= 1'b0;
          if (pending_cmds.size() != 0 && gap_cnt < pending_cmds[0].gap)
            gap_cnt <= gap_cnt + 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_bit = '{line_bit: out_line_bit, last: out_last, overflow: out_overflow};
        n_checked++;
        if (line_bits_due.size() == 0) begin
          note_error($sformatf("unexpected line bit bit=%0b last=%0b ovf=%0b",
                               got_bit.line_bit, got_bit.last, got_bit.overflow));
        end else begin
          want_bit = line_bits_due.pop_front();
          if (got_bit.line_bit !== want_bit.line_bit || got_bit.last !== want_bit.last ||
              got_bit.overflow !== want_bit.overflow)
            note_error($sformatf(
              "line bit %0d: expected bit=%0b last=%0b ovf=%0b, got bit=%0b last=%0b ovf=%0b",
              n_checked, want_bit.line_bit, want_bit.last, want_bit.overflow,
              got_bit.line_bit, got_bit.last, got_bit.overflow));
        end
        stall_left = calm ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int n_dir;
    fsk_q      = 1'b0;
    max_bits_q = 16'd2048;
    clear_frame();
    calm = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // raw mode, wide limit, back to back
    write_cfg(hdlctx_pkg::REG_FSK_MODE, 16'hA5A4);
    write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'hFFFF);
    queue_cmd(hdlctx_pkg::CMD_START, 8'hA5);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h00);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'hFF);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h7E);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h1F);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'hF8);
    queue_cmd(hdlctx_pkg::CMD_FLAG, 8'hFF);
    queue_cmd(hdlctx_pkg::CMD_END, 8'h5A);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h80, 1'b1);
    queue_cmd(hdlctx_pkg::CMD_END, 8'h00);
    wait_idle();

    // scrambler + NRZI
    calm = 1'b0;
    write_cfg(hdlctx_pkg::REG_FSK_MODE, 16'h7FF1);
    queue_cmd(hdlctx_pkg::CMD_START, 8'hFF);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h55);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'hFF);
    queue_cmd(hdlctx_pkg::CMD_FLAG, 8'h00);
    queue_cmd(hdlctx_pkg::CMD_END, 8'hFF);
    wait_idle();

    // zero limit: everything dropped
    write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'h0000);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'hAA);
    queue_cmd(hdlctx_pkg::CMD_START, 8'h00);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'hFF);
    queue_cmd(hdlctx_pkg::CMD_FLAG, 8'h00);
    queue_cmd(hdlctx_pkg::CMD_END, 8'h00);
    wait_idle();

    // overflow inside a byte, then raise limit and switch mode mid-frame
    write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'd20);
    queue_cmd(hdlctx_pkg::CMD_START, 8'h00);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'hFF);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'hFF);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h0F);
    wait_idle();
    write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'hFFFF);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h3C);
    wait_idle();
    write_cfg(hdlctx_pkg::REG_FSK_MODE, 16'h0000);
    queue_cmd(hdlctx_pkg::CMD_END, 8'h00);
    wait_idle();
    write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'd8);
    queue_cmd(hdlctx_pkg::CMD_DATA, 8'h01);
    wait_idle();
    n_dir = n_queued;

    while (n_queued < n_dir + N_RANDOM) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0)
        write_cfg(hdlctx_pkg::REG_FSK_MODE, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'h0000);
          1: write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'hFFFF);
          2: write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'($urandom_range(1, 40)));
          3: write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'($urandom_range(40, 200)));
          4: write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'd2048);
          default: write_cfg(hdlctx_pkg::REG_MAX_BITS, 16'($urandom_range(0, 65535)));
        endcase
      end
      repeat ($urandom_range(1, 3)) queue_frame($urandom_range(0, 5));
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4))
          queue_cmd(hdlctx_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      wait_idle();
    end

    $display("Sent %0d commands (%0d directed) across %0d register writes;",
             n_sent, n_dir, n_cfg);
    $display("checked %0d line bits in raw and scrambled modes, limits 0 to 65535.",
             n_checked);
    if (err_cnt == 0 && line_bits_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d line bits never seen", err_cnt, line_bits_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
